// ===== sv/fimc_pkg.sv =====
// ----------------------------------------------------------------------------
// Fan integral mode controller - shared definitions
// Payload types, register and mode codes, datapath operation codes, constants
// and the microcode table that drives the sequencer.
// ----------------------------------------------------------------------------
package fimc_pkg;

    typedef struct packed {
        logic [9:0]         pot_value;
        logic signed [11:0] temperature;
        logic [9:0]         smoke_adc;
        logic               button_pressed;
        logic [31:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  fan_level;
        logic        alarm;
        logic [1:0]  mode;
        logic [5:0]  temp_setpoint;
        logic [13:0] smoke_ppm;
        logic        control_updated;
    } t_out_item;

    // configuration register indexes
    localparam logic [1:0] CFG_KI_GAIN    = 2'd0;
    localparam logic [1:0] CFG_SMOKE_LIM  = 2'd1;
    localparam logic [1:0] CFG_PERIOD     = 2'd2;
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd3;

    localparam logic [15:0] RST_KI_GAIN   = 16'd256;
    localparam logic [13:0] RST_SMOKE_LIM = 14'd1000;
    localparam logic [15:0] RST_PERIOD    = 16'd1000;
    localparam logic [15:0] RST_DEBOUNCE  = 16'd200;

    // operating modes
    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;

    // multiplier operations
    localparam logic [2:0] MUL_NONE      = 3'd0;
    localparam logic [2:0] MUL_POT40     = 3'd1;
    localparam logic [2:0] MUL_SMOKE9900 = 3'd2;
    localparam logic [2:0] MUL_POT255    = 3'd3;
    localparam logic [2:0] MUL_DIV1023   = 3'd4;
    localparam logic [2:0] MUL_KI_MAG    = 3'd5;
    localparam logic [2:0] MUL_BY_DT     = 3'd6;
    localparam logic [2:0] MUL_DIV125    = 3'd7;

    // register write actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_MODE  = 3'd1;
    localparam logic [2:0] ACT_SP    = 3'd2;
    localparam logic [2:0] ACT_PPM   = 3'd3;
    localparam logic [2:0] ACT_MAN   = 3'd4;
    localparam logic [2:0] ACT_SAT   = 3'd5;
    localparam logic [2:0] ACT_INTEG = 3'd6;
    localparam logic [2:0] ACT_DONE  = 3'd7;

    localparam logic [31:0] K_SP_SCALE   = 32'd40;
    localparam logic [31:0] K_PPM_SCALE  = 32'd9900;
    localparam logic [31:0] K_FAN_SCALE  = 32'd255;
    // ceil(2^34 / 1023), exact for dividends below 2^24
    localparam logic [31:0] RECIP_1023   = 32'd16793617;
    // ceil(2^38 / 125), exact for dividends below 2^31
    localparam logic [31:0] RECIP_125    = 32'd2199023256;
    // ki*mag*dt at or above this gives a step of at least 2^24
    localparam logic [63:0] STEP_SAT_LIM = 64'd1048576000;
    localparam logic [23:0] INTEG_MAX    = 24'hFF0000;
    localparam logic [5:0]  SP_BASE      = 6'd20;
    localparam logic [13:0] PPM_BASE     = 14'd100;

    localparam int          STEP_W    = 4;
    localparam logic [3:0]  STEP_DONE = 4'd10;

    typedef struct packed {
        logic [2:0] mul_op;
        logic [2:0] act;
        logic       jmp_skip;
        logic [3:0] target;
    } t_uword;

    typedef struct packed {
        logic       start;
        logic [2:0] mul_op;
        logic [2:0] act;
    } t_ctrl;

    typedef struct packed {
        logic skip;
        logic out_blocked;
    } t_stat;

    function automatic t_uword ucode(input logic [3:0] step);
        t_uword w;
        w = '{mul_op: MUL_NONE, act: ACT_DONE, jmp_skip: 1'b0, target: STEP_DONE};
        case (step)
            4'd0:  begin w.mul_op = MUL_POT40;     w.act = ACT_MODE;  end
            4'd1:  begin w.mul_op = MUL_DIV1023;   w.act = ACT_NONE;  end
            4'd2:  begin w.mul_op = MUL_SMOKE9900; w.act = ACT_SP;    end
            4'd3:  begin w.mul_op = MUL_DIV1023;   w.act = ACT_NONE;  end
            4'd4:  begin w.mul_op = MUL_POT255;    w.act = ACT_PPM;   end
            4'd5:  begin w.mul_op = MUL_DIV1023;   w.act = ACT_NONE;  end
            4'd6:  begin
                w.mul_op   = MUL_KI_MAG;
                w.act      = ACT_MAN;
                w.jmp_skip = 1'b1;
            end
            4'd7:  begin w.mul_op = MUL_BY_DT;     w.act = ACT_NONE;  end
            4'd8:  begin w.mul_op = MUL_DIV125;    w.act = ACT_SAT;   end
            4'd9:  begin w.mul_op = MUL_NONE;      w.act = ACT_INTEG; end
            default: begin w.mul_op = MUL_NONE;    w.act = ACT_DONE;  end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/fimc_seq.sv =====
// ----------------------------------------------------------------------------
// Fan integral mode controller - microcode sequencer
// Step counter over the control program, conditional skip of the integrator
// steps and input transfer handshake.
// ----------------------------------------------------------------------------
module fimc_seq
    import fimc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    t_uword            uw;
    logic              start;

    assign uw         = ucode(r_step);
    assign start      = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;

    always_comb begin
        o_ctrl.start  = start;
        o_ctrl.mul_op = r_busy ? uw.mul_op : MUL_NONE;
        o_ctrl.act    = ACT_NONE;
        if (r_busy && !(uw.act == ACT_DONE && i_stat.out_blocked)) begin
            o_ctrl.act = uw.act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (uw.act == ACT_DONE) begin
                if (!i_stat.out_blocked) begin
                    r_busy <= 1'b0;
                end
            end else if (uw.jmp_skip && i_stat.skip) begin
                r_step <= uw.target;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= STEP_DONE)
        else $error("step counter beyond program");

    a_finish_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_step) == STEP_DONE && !$past(i_stat.out_blocked))
        else $error("sequencer left busy outside the final step");

endmodule

// ===== sv/fimc_dp.sv =====
// ----------------------------------------------------------------------------
// Fan integral mode controller - datapath
// Configuration registers, item latch, shared multiplier with product
// register, mode and integrator state and the output register.
// ----------------------------------------------------------------------------
module fimc_dp
    import fimc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in_data,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0] r_ki;
    logic [13:0] r_limit;
    logic [15:0] r_period;
    logic [15:0] r_debounce;

    t_in_item    r_item;
    logic [63:0] r_prod;
    logic [5:0]  r_sp;
    logic [13:0] r_ppm;
    logic [7:0]  r_man;
    logic        r_sat;
    logic        r_upd;

    logic [1:0]  r_mode;
    logic [7:0]  r_fan;
    logic [23:0] r_integ;
    logic [31:0] r_last_ctrl;
    logic [31:0] r_last_press;

    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [12:0] err;
    logic [12:0] err_abs;
    logic [11:0] mag;
    logic [31:0] dt;
    logic [31:0] press_dt;
    logic [1:0]  n_mode;
    logic [23:0] q;
    logic [24:0] sum;
    logic [23:0] n_integ;
    logic [7:0]  fan_out;

    assign err     = {r_item.temperature[11], r_item.temperature} - {3'b000, r_sp, 4'b0000};
    assign err_abs = err[12] ? (13'd0 - err) : err;
    assign mag     = err_abs[11:0];
    assign dt      = r_item.now_ms - r_last_ctrl;
    assign press_dt = r_item.now_ms - r_last_press;

    always_comb begin
        case (i_ctrl.mul_op)
            MUL_POT40:     begin mul_a = {22'd0, r_item.pot_value}; mul_b = K_SP_SCALE;  end
            MUL_SMOKE9900: begin mul_a = {22'd0, r_item.smoke_adc}; mul_b = K_PPM_SCALE; end
            MUL_POT255:    begin mul_a = {22'd0, r_item.pot_value}; mul_b = K_FAN_SCALE; end
            MUL_DIV1023:   begin mul_a = {8'd0, r_prod[23:0]};      mul_b = RECIP_1023;  end
            MUL_KI_MAG:    begin mul_a = {16'd0, r_ki};             mul_b = {20'd0, mag}; end
            MUL_BY_DT:     begin mul_a = {4'd0, r_prod[27:0]};      mul_b = dt;          end
            MUL_DIV125:    begin mul_a = {1'b0, r_prod[29:0], 1'b0}; mul_b = RECIP_125;  end
            default:       begin mul_a = '0;                        mul_b = '0;          end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb begin
        case (r_mode)
            MODE_AUTO:   n_mode = MODE_MANUAL;
            MODE_MANUAL: n_mode = MODE_STOP;
            default:     n_mode = MODE_AUTO;
        endcase
    end

    assign q   = r_prod[61:38];
    assign sum = {1'b0, r_integ} + {1'b0, q};

    always_comb begin
        if (err[12]) begin
            n_integ = (r_sat || q > r_integ) ? 24'd0 : r_integ - q;
        end else if (r_sat || q >= INTEG_MAX || sum > {1'b0, INTEG_MAX}) begin
            n_integ = INTEG_MAX;
        end else begin
            n_integ = sum[23:0];
        end
    end

    always_comb begin
        case (r_mode)
            MODE_AUTO:   fan_out = r_fan;
            MODE_MANUAL: fan_out = r_man;
            default:     fan_out = 8'd0;
        endcase
    end

    assign o_stat.skip        = !(r_mode == MODE_AUTO && dt >= {16'd0, r_period});
    assign o_stat.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ki       <= RST_KI_GAIN;
            r_limit    <= RST_SMOKE_LIM;
            r_period   <= RST_PERIOD;
            r_debounce <= RST_DEBOUNCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KI_GAIN:   r_ki       <= i_cfg_wdata;
                CFG_SMOKE_LIM: r_limit    <= i_cfg_wdata[13:0];
                CFG_PERIOD:    r_period   <= i_cfg_wdata;
                CFG_DEBOUNCE:  r_debounce <= i_cfg_wdata;
                default:       r_ki       <= r_ki;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_item <= i_in_data;
        end
        if (i_ctrl.mul_op != MUL_NONE) begin
            r_prod <= mul_p;
        end
        case (i_ctrl.act)
            ACT_SP:  r_sp  <= SP_BASE + r_prod[39:34];
            ACT_PPM: r_ppm <= PPM_BASE + r_prod[47:34];
            ACT_MAN: r_man <= r_prod[41:34];
            ACT_SAT: r_sat <= r_prod >= STEP_SAT_LIM;
            default: r_sat <= r_sat;
        endcase
        if (i_ctrl.act == ACT_DONE) begin
            r_out.fan_level       <= fan_out;
            r_out.alarm           <= r_ppm >= r_limit;
            r_out.mode            <= r_mode;
            r_out.temp_setpoint   <= r_sp;
            r_out.smoke_ppm       <= r_ppm;
            r_out.control_updated <= r_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_AUTO;
            r_fan        <= 8'd0;
            r_integ      <= 24'd0;
            r_last_ctrl  <= 32'd0;
            r_last_press <= 32'd0;
            r_upd        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctrl.start) begin
                r_upd <= 1'b0;
            end
            if (i_ctrl.act == ACT_MODE && r_item.button_pressed
                    && press_dt >= {16'd0, r_debounce}) begin
                r_mode       <= n_mode;
                r_last_press <= r_item.now_ms;
            end
            if (i_ctrl.act == ACT_INTEG) begin
                r_integ     <= n_integ;
                r_fan       <= n_integ[23:16];
                r_last_ctrl <= r_item.now_ms;
                r_upd       <= 1'b1;
            end
            if (i_ctrl.act == ACT_DONE) begin
                r_fan       <= fan_out;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integ <= INTEG_MAX)
        else $error("integrator above full scale");

    a_upd_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upd |-> r_mode == MODE_AUTO && r_fan == r_integ[23:16])
        else $error("integrator update outside automatic mode");

endmodule

// ===== sv/fan_integral_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// Fan integral mode controller - top level
// Mode selection, integral cooling loop with clamp, and smoke alarm.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one control pass (pot, temperature,
// smoke reading, press flag, millisecond time). Output channel: o_out_valid /
// i_out_stall carry one result per pass. A transfer happens when valid is high
// and stall is low.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 gain, 1 smoke limit, 2 control period, 3 debounce); write only while idle.
// Each pass runs a microcoded program over one shared 32x32 multiplier, one
// step a cycle except where the last step waits on the output: 8 steps
// when the integrator does not run, 11 when it does. The result is
// registered at the last step and appears in the cycle after it; one pass
// is in flight at a time, and o_in_stall is high while busy.
// The output register frees the sequencer; if a result is still held by a
// stalled receiver when the next one finishes, the last step waits.
// Reset (synchronous, active low) restores register defaults, automatic mode,
// zero fan level and integrator, and zero timestamps.
// ----------------------------------------------------------------------------
module fan_integral_mode_controller_top
    import fimc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    t_ctrl ctrl;
    t_stat stat;

    fimc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    fimc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Fan integral mode controller - testbench
// Drives control passes through the valid/stall channels and predicts each
// result: debounced mode cycling, setpoint and ppm mapping, smoke alarm and
// the clamped integral cooling loop with wrapping millisecond time. Runs a
// directed opening, then random phases over several register settings with
// sender idling, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
    import fimc_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_PASSES  = 100;
    localparam int PHASE_COUNT   = 8;

    class fan_ctrl_scoreboard;
        logic [15:0] ki_gain     = RST_KI_GAIN;
        logic [13:0] smoke_limit = RST_SMOKE_LIM;
        logic [15:0] period_ms   = RST_PERIOD;
        logic [15:0] debounce_ms = RST_DEBOUNCE;
        logic [1:0]  mode        = MODE_AUTO;
        logic [7:0]  fan         = '0;
        logic [23:0] integ       = '0;
        logic [31:0] last_ctrl   = '0;
        logic [31:0] last_press  = '0;
        t_out_item   pending_outcomes[$];
        int          mismatches  = 0;

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_KI_GAIN:   ki_gain     = value;
                CFG_SMOKE_LIM: smoke_limit = value[13:0];
                CFG_PERIOD:    period_ms   = value;
                CFG_DEBOUNCE:  debounce_ms = value;
                default: ;
            endcase
        endfunction

        function t_out_item fan_pass_outcome(t_in_item p);
            t_out_item        r;
            int unsigned      sp;
            int unsigned      ppm;
            int               err;
            logic [31:0]      since;
            longint unsigned  k, m, d, stp, acc;
            r = '0;
            sp = 20 + (32'(p.pot_value) * 40) / 1023;
            ppm = 100 + (32'(p.smoke_adc) * 9900) / 1023;
            since = p.now_ms - last_press;
            if (p.button_pressed && since >= 32'(debounce_ms)) begin
                case (mode)
                    MODE_AUTO:   mode = MODE_MANUAL;
                    MODE_MANUAL: mode = MODE_STOP;
                    default:     mode = MODE_AUTO;
                endcase
                last_press = p.now_ms;
            end
            case (mode)
                MODE_AUTO: begin
                    since = p.now_ms - last_ctrl;
                    if (since >= 32'(period_ms)) begin
                        err = int'($signed(p.temperature)) - 16 * int'(sp);
                        k = 64'(ki_gain);
                        m = 64'((err < 0) ? -err : err);
                        d = 64'(since);
                        stp = (k * m * d * 64'd2) / 64'd125;
                        acc = 64'(integ);
                        if (err < 0) begin
                            acc = (stp > acc) ? 64'd0 : acc - stp;
                        end else begin
                            acc = (stp >= 64'(INTEG_MAX)) ? 64'(INTEG_MAX) : acc + stp;
                        end
                        if (acc > 64'(INTEG_MAX)) acc = 64'(INTEG_MAX);
                        integ = acc[23:0];
                        fan = integ[23:16];
                        last_ctrl = p.now_ms;
                        r.control_updated = 1'b1;
                    end
                end
                MODE_MANUAL: fan = 8'((32'(p.pot_value) * 255) / 1023);
                default:     fan = '0;
            endcase
            r.fan_level     = fan;
            r.alarm         = (ppm >= 32'(smoke_limit));
            r.mode          = mode;
            r.temp_setpoint = sp[5:0];
            r.smoke_ppm     = ppm[13:0];
            return r;
        endfunction

        function void note_pass(t_in_item p);
            pending_outcomes.push_back(fan_pass_outcome(p));
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending_outcomes.size() == 0) begin
                $error("result with no pass outstanding: %h", got);
                mismatches++;
                return;
            end
            exp_r = pending_outcomes.pop_front();
            if (got.fan_level !== exp_r.fan_level) begin
                $error("fan_level expected %0d actual %0d", exp_r.fan_level, got.fan_level);
                mismatches++;
            end
            if (got.alarm !== exp_r.alarm) begin
                $error("alarm expected %0d actual %0d", exp_r.alarm, got.alarm);
                mismatches++;
            end
            if (got.mode !== exp_r.mode) begin
                $error("mode expected %0d actual %0d", exp_r.mode, got.mode);
                mismatches++;
            end
            if (got.temp_setpoint !== exp_r.temp_setpoint) begin
                $error("temp_setpoint expected %0d actual %0d",
                       exp_r.temp_setpoint, got.temp_setpoint);
                mismatches++;
            end
            if (got.smoke_ppm !== exp_r.smoke_ppm) begin
                $error("smoke_ppm expected %0d actual %0d", exp_r.smoke_ppm, got.smoke_ppm);
                mismatches++;
            end
            if (got.control_updated !== exp_r.control_updated) begin
                $error("control_updated expected %0d actual %0d",
                       exp_r.control_updated, got.control_updated);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    t_in_item    in_data     = '0;
    logic        out_stall   = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_idx     = CFG_KI_GAIN;
    logic [15:0] cfg_wdata   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;

    fan_ctrl_scoreboard sb = new();

    int          snd_idle    = 0;
    int          rcv_stall   = 0;
    int unsigned hold_req    = 0;
    int unsigned hold_seen   = 0;
    int          hold_left   = 0;
    int          quiet_count = 0;
    logic [31:0] now_cursor  = '0;
    int unsigned cur_period  = 32'(RST_PERIOD);

    fan_integral_mode_controller_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            sb.check_result(o_out_data);
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_stall);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
            quiet_count = 0;
        end else begin
            quiet_count++;
        end
        if (quiet_count >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in_item mk_pass(int pot, int temp, int smoke, bit press,
                                         logic [31:0] now);
        t_in_item p;
        p.pot_value      = 10'(pot);
        p.temperature    = 12'(temp);
        p.smoke_adc      = 10'(smoke);
        p.button_pressed = press;
        p.now_ms         = now;
        return p;
    endfunction

    function automatic t_in_item random_pass();
        int pot, sp, temp, sel;
        pot = $urandom_range(1023);
        sp = 20 + (pot * 40) / 1023;
        sel = $urandom_range(99);
        if (sel < 70) begin
            temp = 16 * sp + $urandom_range(320) - 160;
        end else if (sel < 90) begin
            temp = $urandom_range(2000) - 640;
        end else begin
            temp = $urandom;
        end
        sel = $urandom_range(99);
        if (sel < 85) begin
            now_cursor += $urandom_range(2 * cur_period);
        end else if (sel < 95) begin
            now_cursor += $urandom_range(300);
        end else begin
            now_cursor = $urandom;
        end
        return mk_pass(pot, temp, $urandom_range(1023), $urandom_range(99) < 15, now_cursor);
    endfunction

    task automatic send_pass(input t_in_item p);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_pass(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] ki, lim, per, deb);
        logic [15:0] vals [4];
        vals[CFG_KI_GAIN]   = ki;
        vals[CFG_SMOKE_LIM] = lim;
        vals[CFG_PERIOD]    = per;
        vals[CFG_DEBOUNCE]  = deb;
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= 2'(i);
            cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.set_reg(2'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        cur_period = 32'(per);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opening passes run on the reset register values
        send_pass(mk_pass(0, -2048, 0, 1'b0, 32'd0));
        send_pass(mk_pass(1023, 2047, 1023, 1'b0, 32'd1000));
        send_pass(mk_pass(0, -2048, 1023, 1'b0, 32'd2000));
        send_pass(mk_pass(512, 800, 93, 1'b0, 32'd2100));
        send_pass(mk_pass(0, 320, 92, 1'b0, 32'd3100));
        send_pass(mk_pass(1023, 976, 512, 1'b1, 32'd3150));
        send_pass(mk_pass(1023, 976, 512, 1'b1, 32'd3200));
        send_pass(mk_pass(700, 100, 300, 1'b1, 32'd3350));
        send_pass(mk_pass(700, 100, 300, 1'b0, 32'd5000));
        send_pass(mk_pass(400, 600, 700, 1'b1, 32'd5600));
        send_pass(mk_pass(400, 600, 700, 1'b0, 32'd5900));
        send_pass(mk_pass(400, 400, 700, 1'b0, 32'd7000));
        send_pass(mk_pass(1023, 1360, 1, 1'b0, 32'hFFFF_FF00));
        send_pass(mk_pass(1023, 1360, 1, 1'b0, 32'h0000_0100));
        send_pass(mk_pass(1023, -640, 1, 1'b0, 32'h0000_0400));
        send_pass(mk_pass(256, 500, 1022, 1'b1, 32'h0000_0410));
        send_pass(mk_pass(256, 500, 1022, 1'b1, 32'hFFFF_FFFF));
        send_pass(mk_pass(256, 500, 1022, 1'b1, 32'h0000_1000));
        send_pass(mk_pass(511, 700, 511, 1'b0, 32'h0000_2000));
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: program_regs(RST_KI_GAIN, 16'(RST_SMOKE_LIM), RST_PERIOD, RST_DEBOUNCE);
                1: program_regs(16'd0, 16'd100, 16'd1, 16'd0);
                2: program_regs(16'd65535, 16'd10000, 16'd65535, 16'd65535);
                5: program_regs(16'd40, 16'd5000, 16'd50, 16'd0);
                default: program_regs(16'($urandom_range(600)),
                                      16'($urandom_range(10000, 100)),
                                      16'($urandom_range(3000, 1)),
                                      16'($urandom_range(2000)));
            endcase
            case (ph % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 78; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 78; end
                default: begin snd_idle = 37; rcv_stall = 37; end
            endcase
            if (ph == 3) begin
                snd_idle = 0;
                rcv_stall = 0;
                hold_req <= hold_req + 1;
            end
            repeat (PHASE_PASSES) send_pass(random_pass());
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fimc_pkg.sv
sv/fimc_seq.sv
sv/fimc_dp.sv
sv/fan_integral_mode_controller_top.sv
test/tb_top.sv
